// File: design/sswg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sswg_pkg
// Shared constants, register indexes and sine table for the wave generator.
// ----------------------------------------------------------------------------
package sswg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int TAB_SIZE = 1 << SINE_TABLE_BITS;
  localparam int QUARTER = TAB_SIZE / 4;
  localparam real HALF_PI_STEP = 3.14159265358979323846 / 2.0 / real'(QUARTER);

  localparam int STEP_W = 31;
  localparam int PER_W = 16;
  localparam int AMP_W = 31;
  localparam int OFS_W = 32;
  localparam int DUTY_W = 17;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY = 3'd4;

  localparam logic WAVE_RECT = 1'b0;
  localparam logic WAVE_SINE = 1'b1;

  // round(32767*sin(2*pi*i/TAB_SIZE)), half away from zero, quarter wave mirrored
  function automatic logic signed [15:0] sine_lookup(input logic [SINE_TABLE_BITS-1:0] i);
    int quad;
    int r;
    int j;
    int mag;
    real v;
    quad = int'(i >> (SINE_TABLE_BITS - 2));
    r = int'(i) & (QUARTER - 1);
    j = ((quad & 1) != 0) ? QUARTER - r : r;
    v = 32767.0 * $sin(HALF_PI_STEP * real'(j));
    mag = int'($floor(v + 0.5));
    return ((quad & 2) != 0) ? -16'(mag) : 16'(mag);
  endfunction

endpackage : sswg_pkg
`default_nettype wire

// File: design/sine_square_wave_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sine_square_wave_generator
// Rectangular or sine sample for each step index, saturated Q16.16.
// ----------------------------------------------------------------------------
// One step index is taken per clock (start while busy is low; busy is always
// low). Each sample comes out with done high for one cycle, after passing
// through an input register, then the step mod period by a restoring divider
// pipeline, one quotient bit per stage (31 stages), then the phase
// m*65536/period by a second one (16 stages), then table lookup, one multiply
// and saturation, one stage each. The receiver cannot stall the result.
module sine_square_wave_generator (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire  [sswg_pkg::STEP_W-1:0]      step_index,
  input  wire                              cfg_we,
  input  wire  [sswg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [sswg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             done,
  output logic signed [31:0]               sample_value
);
  import sswg_pkg::*;

  localparam int NR = STEP_W;   // remainder stages
  localparam int NP = 16;       // phase quotient stages
  localparam int RW = PER_W + 1;

  logic              wave_mode;
  logic [PER_W-1:0]  period_steps;
  logic [AMP_W-1:0]  amplitude;
  logic signed [OFS_W-1:0] offset_level;
  logic [DUTY_W-1:0] duty_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode <= WAVE_RECT;
      period_steps <= 16'd20;
      amplitude <= 31'd65536;
      offset_level <= '0;
      duty_fraction <= 17'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVE_MODE: wave_mode <= cfg_data[0];
        REG_PERIOD:    period_steps <= cfg_data[PER_W-1:0];
        REG_AMPLITUDE: amplitude <= cfg_data[AMP_W-1:0];
        REG_OFFSET:    offset_level <= cfg_data;
        REG_DUTY:      duty_fraction <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // constant sine table
  logic signed [15:0] sine_rom [TAB_SIZE];
  for (genvar i = 0; i < TAB_SIZE; i++) begin : g_rom
    localparam logic signed [15:0] ROM_VAL = sine_lookup(SINE_TABLE_BITS'(i));
    assign sine_rom[i] = ROM_VAL;
  end

  // remainder pipeline: stage k consumes dividend bit NR-1-k
  logic [NR:0]        rv;
  logic [RW-1:0]      rrem [NR+1];
  logic [STEP_W-1:0]  rdvd [NR+1];

  assign rrem[0] = '0;

  // stage 0 registers the raw step; stages act on registered values
  always_ff @(posedge clk) begin
    if (rst) rv[0] <= 1'b0;
    else rv[0] <= start;
    rdvd[0] <= step_index;
  end

  for (genvar k = 0; k < NR; k++) begin : g_rem
    logic [RW-1:0] sh;
    logic [RW-1:0] src;
    logic [STEP_W-1:0] dsrc;
    assign src  = rrem[k];
    assign dsrc = rdvd[k];
    assign sh = {src[RW-2:0], dsrc[NR-1-k]};
    always_ff @(posedge clk) begin
      if (rst) rv[k+1] <= 1'b0;
      else rv[k+1] <= rv[k];
      rrem[k+1] <= (sh >= {1'b0, period_steps}) ? sh - {1'b0, period_steps} : sh;
      rdvd[k+1] <= dsrc;
    end
  end

  // phase pipeline: quotient bits of m*65536/period
  logic [NP:0]       pv;
  logic [RW-1:0]     prem [NP+1];
  logic [NP-1:0]     pq   [NP+1];
  logic [PER_W-1:0]  pm   [NP+1];

  assign pv[0] = rv[NR];
  assign prem[0] = rrem[NR];
  assign pq[0] = '0;
  assign pm[0] = rrem[NR][PER_W-1:0];

  for (genvar k = 0; k < NP; k++) begin : g_ph
    logic [RW-1:0] sh;
    logic ge;
    assign sh = {prem[k][RW-2:0], 1'b0};
    assign ge = sh >= {1'b0, period_steps};
    always_ff @(posedge clk) begin
      if (rst) pv[k+1] <= 1'b0;
      else pv[k+1] <= pv[k];
      prem[k+1] <= ge ? sh - {1'b0, period_steps} : sh;
      pq[k+1] <= {pq[k][NP-2:0], ge};
      pm[k+1] <= pm[k];
    end
  end

  // lookup and compare stage
  logic                 l_v;
  logic signed [15:0]   l_sin;
  logic                 l_high;
  always_ff @(posedge clk) begin
    if (rst) l_v <= 1'b0;
    else l_v <= pv[NP];
    l_sin <= sine_rom[pq[NP][NP-1 -: SINE_TABLE_BITS]];
    l_high <= ({1'b0, pm[NP], 16'd0} < 33'(period_steps) * 33'(duty_fraction));
  end

  // multiply stage
  logic                 x_v;
  logic signed [47:0]   x_p;
  logic                 x_high;
  always_ff @(posedge clk) begin
    if (rst) x_v <= 1'b0;
    else x_v <= l_v;
    x_p <= $signed({1'b0, amplitude}) * l_sin;
    x_high <= l_high;
  end

  // sum and saturate
  logic signed [33:0] sum;
  always_comb begin
    if (period_steps == '0) begin
      sum = 34'(offset_level);
    end else if (wave_mode == WAVE_SINE) begin
      sum = 34'(x_p >>> 15) + 34'(offset_level);
    end else if (x_high) begin
      sum = 34'(offset_level) + 34'({1'b0, amplitude});
    end else begin
      sum = 34'(offset_level) - 34'({1'b0, amplitude});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= x_v;
    if (sum > 34'sd2147483647) sample_value <= 32'h7fffffff;
    else if (sum < -34'sd2147483648) sample_value <= 32'h80000000;
    else sample_value <= sum[31:0];
  end

`ifndef SYNTH
  a_lat: assert property (@(posedge clk) disable iff (rst) pv[0] |-> ##19 done)
    else $error("sample lost in pipeline");
  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_rem: assert property (@(posedge clk) disable iff (rst)
    (pv[0] && period_steps != '0) |-> (pm[0] < period_steps))
    else $error("remainder out of range");
`endif

endmodule : sine_square_wave_generator
`default_nettype wire

// File: dv/sswg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswg_checker
// Watches the step, config and sample channels of the wave generator, works
// out each sample from its own copy of the registers and sine table, and
// compares every sample with the oldest one still owed.
// ----------------------------------------------------------------------------
module sswg_checker
  import sswg_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire                    busy,
  input  wire [STEP_W-1:0]       step_index,
  input  wire                    cfg_we,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data,
  input  wire                    done,
  input  wire signed [31:0]      sample_value,
  output int                     errors,
  output int                     owed,
  output int                     samples_seen
);

  logic signed [15:0] sine_tab [TAB_SIZE];
  logic               mode_q;
  logic [PER_W-1:0]   period_q;
  logic [AMP_W-1:0]   amp_q;
  logic signed [31:0] ofs_q;
  logic [DUTY_W-1:0]  duty_q;
  logic signed [31:0] owed_samples[$];

  // quarter wave mirrored into the full table
  initial begin
    int quad, r, j;
    real v;
    for (int i = 0; i < TAB_SIZE; i++) begin
      quad = i >> (SINE_TABLE_BITS - 2);
      r = i % (TAB_SIZE / 4);
      j = (quad % 2 == 1) ? TAB_SIZE / 4 - r : r;
      v = 32767.0 * $sin(3.14159265358979323846 / 2.0 * j / (TAB_SIZE / 4));
      sine_tab[i] = 16'($rtoi($floor(v + 0.5)));
      if (quad >= 2) sine_tab[i] = -sine_tab[i];
    end
  end

  function automatic logic signed [31:0] wave_sample(input logic [STEP_W-1:0] stp);
    longint m, acc, p;
    logic [15:0] phase;
    if (period_q == 0) return ofs_q;
    m = longint'(stp) % longint'(period_q);
    if (mode_q == WAVE_RECT) begin
      if (m * 65536 < longint'(period_q) * longint'(duty_q))
        acc = longint'(ofs_q) + longint'(amp_q);
      else
        acc = longint'(ofs_q) - longint'(amp_q);
    end else begin
      phase = 16'((m * 65536) / longint'(period_q));
      p = longint'(amp_q) * longint'(sine_tab[phase[15 -: SINE_TABLE_BITS]]);
      acc = (p >>> 15) + longint'(ofs_q);  // floor division by 32768
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return 32'(acc);
  endfunction

  assign owed = owed_samples.size();

  always @(posedge clk) begin
    logic signed [31:0] want;
    if (rst) begin
      mode_q <= WAVE_RECT;
      period_q <= 16'd20;
      amp_q <= 31'd65536;
      ofs_q <= 32'sd0;
      duty_q <= 17'd32768;
      owed_samples.delete();
      errors <= 0;
      samples_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WAVE_MODE: mode_q <= cfg_data[0];
          REG_PERIOD:    period_q <= cfg_data[PER_W-1:0];
          REG_AMPLITUDE: amp_q <= cfg_data[AMP_W-1:0];
          REG_OFFSET:    ofs_q <= cfg_data;
          REG_DUTY:      duty_q <= cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (done) begin
        samples_seen <= samples_seen + 1;
        if (owed_samples.size() == 0) begin
          $error("sample_value: nothing expected, got %0d", sample_value);
          errors <= errors + 1;
        end else begin
          want = owed_samples.pop_front();
          if (sample_value !== want) begin
            $error("sample_value: expected %0d, got %0d", want, sample_value);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) owed_samples.push_back(wave_sample(step_index));
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Wave generator testbench: directed and random step indexes over a series
// of register settings, sent in random bursts; checking is in sswg_checker.
// ----------------------------------------------------------------------------
module tb;
  import sswg_pkg::*;

  localparam int LATENCY = 50;
  localparam int STALL_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [STEP_W-1:0]     step_index = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire                   busy;
  wire                   done;
  wire signed [31:0]     sample_value;
  int                    errors, owed, samples_seen;
  int                    quiet_cycles = 0;
  int                    steps_sent = 0;
  int                    settings_run = 0;

  always #5 clk = ~clk;

  sine_square_wave_generator dut (
    .clk, .rst, .start, .busy, .step_index, .cfg_we, .cfg_index, .cfg_data,
    .done, .sample_value
  );

  sswg_checker chk (
    .clk, .rst, .start, .busy, .step_index, .cfg_we, .cfg_index, .cfg_data,
    .done, .sample_value, .errors, .owed, .samples_seen
  );

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (owed != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic mode, input logic [15:0] per,
                               input logic [30:0] amp, input logic [31:0] ofs,
                               input logic [16:0] duty);
    wait_idle();
    write_reg(REG_WAVE_MODE, {31'd0, mode});
    write_reg(REG_PERIOD, {16'd0, per});
    write_reg(REG_AMPLITUDE, {1'b0, amp});
    write_reg(REG_OFFSET, ofs);
    write_reg(REG_DUTY, {15'd0, duty});
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // one beat; start stays high inside a burst and drops only for a gap
  task automatic send_step(input logic [STEP_W-1:0] v, input int gap);
    start <= 1'b1;
    step_index <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    steps_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_steps(input int n, input int per);
    int burst = 0;
    int gap;
    logic [STEP_W-1:0] v;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom_range(0, (per == 0 ? 8 : 3 * per));
        1: v = STEP_W'($urandom);
        2: v = (per == 0) ? STEP_W'($urandom) : STEP_W'($urandom_range(0, 60000) * per
                                                 + $urandom_range(0, 1) * (per - 1));
        default: v = $urandom_range(0, 1) ? '1 : STEP_W'($urandom_range(0, 3));
      endcase
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else gap = 0;
      burst--;
      send_step(v, burst == 0 ? gap : 0);
    end
    start <= 1'b0;
  endtask

  initial begin
    logic [15:0] per;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset setting, then each mode at the extremes
    send_step(0, 0); send_step(10, 0); send_step(19, 0); send_step('1, 0);
    send_step(20, 1);
    apply_setting(WAVE_SINE, 16'd20, 31'd65536, 32'd0, 17'd32768);
    for (int k = 0; k < 6; k++) send_step(k * 5 + 1, 0);
    send_step('1, 1);
    apply_setting(WAVE_SINE, 16'd65535, 31'h7fffffff, 32'h7fffffff, 17'd0);
    send_step(16384, 0); send_step(49151, 0); send_step('1, 1);
    apply_setting(WAVE_RECT, 16'd0, 31'd123, 32'h80000000, 17'd65536);
    send_step(5, 0); send_step('1, 1);
    apply_setting(WAVE_RECT, 16'd7, 31'h7fffffff, 32'h80000000, 17'd131071);
    send_step(0, 0); send_step(6, 1);
    apply_setting(WAVE_RECT, 16'd1, 31'h7fffffff, 32'h7fffffff, 17'd0);
    send_step(0, 0); send_step(3, 1);
    start <= 1'b0;

    for (int s = 0; s < 12; s++) begin
      case (s % 4)
        0: per = $urandom_range(1, 64);
        1: per = $urandom_range(1, 2000);
        2: per = 16'($urandom);
        default: per = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'd65535;
      endcase
      apply_setting(s % 2 ? WAVE_SINE : WAVE_RECT, per,
                    ($urandom_range(0, 3) == 0) ? 31'h7fffffff : 31'($urandom),
                    $urandom, ($urandom_range(0, 2) == 0) ? 17'($urandom)
                                                           : 17'($urandom_range(0, 65536)));
      random_steps(86, per);
    end

    wait_idle();
    $display("covered %0d step indexes over %0d register settings, %0d samples checked",
             steps_sent, settings_run, samples_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/sswg_pkg.sv
design/sine_square_wave_generator.sv
dv/sswg_checker.sv
dv/tb.sv
